FILE: rtl/accel_delta_frame_decoder_unit_assert.svh
// Assertion macros for the delta frame decoder; clk and rst_n are taken from the including scope.
`ifndef ACCEL_DELTA_FRAME_DECODER_UNIT_ASSERT_SVH
`define ACCEL_DELTA_FRAME_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ADF_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adf: same-cycle check failed");

// Next-cycle implication.
`define ADF_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adf: next-cycle check failed");

`endif

FILE: rtl/adf_pkg.sv
// Shared types and constants of the delta frame decoder.
package adf_pkg;

  // byte classes assigned by the front end
  typedef logic [1:0] tag_t;
  localparam tag_t TAG_FIRST = 2'd0;
  localparam tag_t TAG_KIND  = 2'd1;
  localparam tag_t TAG_BODY  = 2'd2;
  localparam tag_t TAG_SKIP  = 2'd3;

  // decode phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_RAW     = 3'd1;
  localparam logic [2:0] PH_WIDTH   = 3'd2;
  localparam logic [2:0] PH_COUNT   = 3'd3;
  localparam logic [2:0] PH_DELTAS  = 3'd4;
  localparam logic [2:0] PH_STOPPED = 3'd5;

  localparam logic [7:0] MEAS_TYPE    = 8'h02;
  localparam logic [7:0] KIND_RAW     = 8'h01;
  localparam logic [4:0] POS_SAT      = 5'd16;
  localparam logic [4:0] POS_KIND     = 5'd9;
  localparam logic [4:0] POS_BODY     = 5'd10;
  localparam int         TRIPLE_BYTES = 6;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    tag_t       tag;
    logic [7:0] data_byte;
    logic       frame_last;
  } q_item_t;

  // back end status seen by the top level
  typedef struct packed {
    logic [2:0] phase;
    logic       emit;
    logic       pop_last;
  } bk_stat_t;

endpackage

FILE: rtl/adf_in_if.sv
// Input byte channel.
interface adf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

FILE: rtl/adf_out_if.sv
// Sample result channel.
interface adf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic               last_in_run;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  output last_in_run, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  input last_in_run, output ready);
endinterface

FILE: rtl/adf_q_if.sv
// Classified byte channel between front end, queue and back end.
interface adf_q_if;
  import adf_pkg::*;
  logic    valid;
  logic    ready;
  q_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

FILE: rtl/accel_delta_frame_decoder_unit.sv
// Top level of the accelerometer delta frame decoder.
// Decodes measurement frames arriving one byte per beat on in_if (frame_last on the final
// byte) into x,y,z samples on out_if, last_in_run marking the final sample a byte yields.
// Byte 0 must be 0x02, byte 9 selects raw triples (0x01) or delta groups; bytes 10..15
// give the first sample. A front end tags each byte with its frame position and pushes
// it into a four-entry queue; the back end decodes from the queue head into a one-beat
// output register, so input beats keep flowing while a sample waits on out_if, until the
// queue fills. A delta byte stays at the queue head while the deltas that end inside it
// are extracted and, if it closes with a delta still open, while its last bits are gathered:
// the back end extracts one delta per cycle, but stalls when a sample completes while the
// output register still holds one not yet taken. Samples cut short by frame end are
// dropped; sums wrap at 16 bits and carry over between frames. No clearing pass is needed
// after reset.
`include "accel_delta_frame_decoder_unit_assert.svh"

module accel_delta_frame_decoder_unit #(
  parameter int MAX_DELTA_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  adf_in_if.sink    in_if,
  adf_out_if.source out_if
);
  import adf_pkg::*;

  adf_q_if  fq_if ();   // front end -> queue
  adf_q_if  qb_if ();   // queue -> back end
  bk_stat_t bk_stat;
  logic     emit_phase_ok;

  adf_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .q_if  (fq_if)
  );

  adf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_if (fq_if),
    .rd_if (qb_if)
  );

  adf_back #(
    .MAX_DELTA_BITS (MAX_DELTA_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_if   (qb_if),
    .out_if (out_if),
    .stat   (bk_stat)
  );

  assign emit_phase_ok = (bk_stat.phase == PH_HEADER) || (bk_stat.phase == PH_RAW) ||
                         (bk_stat.phase == PH_DELTAS);

  // samples only come from header, raw or delta decoding
  `ADF_AST_IMP(a_emit_phase, bk_stat.emit, emit_phase_ok)
  // a held sample is never overwritten
  `ADF_AST_IMP(a_out_hold, out_if.valid && !out_if.ready, !bk_stat.emit)
  // retiring the final byte of a frame returns the decoder to the header phase
  `ADF_AST_NXT(a_frame_end, bk_stat.pop_last, bk_stat.phase == PH_HEADER)

endmodule

FILE: rtl/adf_front.sv
// Front end: tracks the byte position in the frame and tags each byte.
module adf_front (
  input  logic clk,
  input  logic rst_n,
  adf_in_if.sink   in_if,
  adf_q_if.source  q_if
);
  import adf_pkg::*;

  logic [4:0] pos_r, pos_nxt;
  tag_t       tag;

  always_comb begin
    if (pos_r == 5'd0) begin
      tag = TAG_FIRST;
    end else if (pos_r == POS_KIND) begin
      tag = TAG_KIND;
    end else if (pos_r >= POS_BODY) begin
      tag = TAG_BODY;
    end else begin
      tag = TAG_SKIP;
    end
  end

  assign q_if.valid           = in_if.valid;
  assign in_if.ready          = q_if.ready;
  assign q_if.item.tag        = tag;
  assign q_if.item.data_byte  = in_if.data_byte;
  assign q_if.item.frame_last = in_if.frame_last;

  always_comb begin
    pos_nxt = pos_r;
    if (in_if.valid && q_if.ready) begin
      if (in_if.frame_last) begin
        pos_nxt = 5'd0;
      end else if (pos_r < POS_SAT) begin
        pos_nxt = pos_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 5'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

FILE: rtl/adf_queue.sv
// Small FIFO of tagged bytes between front end and back end.
module adf_queue (
  input  logic clk,
  input  logic rst_n,
  adf_q_if.sink   wr_if,
  adf_q_if.source rd_if
);
  import adf_pkg::*;

  q_item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, rp_r;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push, pop;

  assign wr_if.ready = (cnt_r != QCNT_W'(QDEPTH));
  assign rd_if.valid = (cnt_r != '0);
  assign rd_if.item  = mem_r[rp_r];

  assign push = wr_if.valid && wr_if.ready;
  assign pop  = rd_if.valid && rd_if.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_if.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QPTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/adf_back.sv
// Back end: phase machine, triple gathering, one-delta-per-cycle extractor, output register.
module adf_back #(
  parameter int MAX_DELTA_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  adf_q_if.sink          q_if,
  adf_out_if.source      out_if,
  output adf_pkg::bk_stat_t stat
);
  import adf_pkg::*;

  localparam int DW_W = $clog2(MAX_DELTA_BITS + 1);

  logic [2:0]      phase_r, phase_nxt;
  logic [7:0]      kind_r, kind_nxt;
  logic [15:0]     sx_r, sx_nxt, sy_r, sy_nxt, sz_r, sz_nxt;
  logic [39:0]     gath_r, gath_nxt;
  logic [2:0]      gcnt_r, gcnt_nxt;
  logic [DW_W-1:0] dw_r, dw_nxt;
  logic [7:0]      left_r, left_nxt;
  logic [1:0]      axis_r, axis_nxt;
  logic [15:0]     part_r, part_nxt;
  logic [DW_W-1:0] pb_r, pb_nxt;
  logic [2:0]      off_r, off_nxt;

  logic            ov_r, ov_nxt;
  logic [15:0]     ox_r, oy_r, oz_r;
  logic            olast_r;

  q_item_t         item;
  logic [7:0]      b;
  logic            gfull;
  logic            emit, done, smp_last, go, out_free;

  // delta extractor signals
  logic [DW_W-1:0] need;
  logic [7:0]      need8, avail8, take8;
  logic [3:0]      take, off_new;
  logic [7:0]      chunk;
  logic [15:0]     part_new, dval;
  logic            complete, sign;
  logic [7:0]      left_dec, room, need3;

  assign item  = q_if.item;
  assign b     = item.data_byte;
  assign gfull = (gcnt_r == 3'(TRIPLE_BYTES - 1));

  always_comb begin
    need     = dw_r - pb_r;
    need8    = 8'(need);
    avail8   = 8'd8 - 8'(off_r);
    take8    = (need8 < avail8) ? need8 : avail8;
    take     = take8[3:0];
    chunk    = (b >> off_r) & ~(8'hFF << take);
    part_new = part_r | ((8'(pb_r) < 8'd16) ? (16'(chunk) << pb_r[3:0]) : 16'd0);
    complete = (need8 == take8);
    sign     = part_new[4'(dw_r[3:0] - 4'd1)];
    if ((8'(dw_r) < 8'd16) && sign) begin
      dval = part_new | (16'hFFFF << dw_r[3:0]);
    end else begin
      dval = part_new;
    end
    off_new  = 4'(off_r) + take;
    left_dec = left_r - 8'd1;
    room     = 8'(4'd8 - off_new);
    need3    = (8'(dw_r) << 1) + 8'(dw_r);
  end

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    sz_nxt    = sz_r;
    gath_nxt  = gath_r;
    gcnt_nxt  = gcnt_r;
    dw_nxt    = dw_r;
    left_nxt  = left_r;
    axis_nxt  = axis_r;
    part_nxt  = part_r;
    pb_nxt    = pb_r;
    emit      = 1'b0;
    done      = 1'b1;
    smp_last  = 1'b1;

    case (phase_r)
      PH_HEADER, PH_RAW: begin
        if (phase_r == PH_HEADER && item.tag == TAG_FIRST) begin
          if (b != MEAS_TYPE) begin
            phase_nxt = PH_STOPPED;
          end
        end else if (phase_r == PH_HEADER && item.tag == TAG_KIND) begin
          kind_nxt = b;
        end else if (phase_r == PH_RAW || item.tag == TAG_BODY) begin
          if (gfull) begin
            sx_nxt   = gath_r[15:0];
            sy_nxt   = gath_r[31:16];
            sz_nxt   = {b, gath_r[39:32]};
            gath_nxt = '0;
            gcnt_nxt = '0;
            emit     = 1'b1;
            if (phase_r == PH_HEADER) begin
              phase_nxt = (kind_r == KIND_RAW) ? PH_RAW : PH_WIDTH;
            end
          end else begin
            gath_nxt = gath_r | (40'(b) << {gcnt_r, 3'b000});
            gcnt_nxt = gcnt_r + 3'd1;
          end
        end
      end
      PH_WIDTH: begin
        if (b == 8'd0 || b > 8'(MAX_DELTA_BITS)) begin
          phase_nxt = PH_STOPPED;
        end else begin
          dw_nxt    = b[DW_W-1:0];
          phase_nxt = PH_COUNT;
        end
      end
      PH_COUNT: begin
        left_nxt  = b;
        axis_nxt  = '0;
        part_nxt  = '0;
        pb_nxt    = '0;
        phase_nxt = (b == 8'd0) ? PH_WIDTH : PH_DELTAS;
      end
      PH_DELTAS: begin
        done = (off_new == 4'd8);
        if (complete) begin
          part_nxt = '0;
          pb_nxt   = '0;
          case (axis_r)
            2'd0: begin
              sx_nxt   = sx_r + dval;
              axis_nxt = 2'd1;
            end
            2'd1: begin
              sy_nxt   = sy_r + dval;
              axis_nxt = 2'd2;
            end
            default: begin
              sz_nxt   = sz_r + dval;
              axis_nxt = 2'd0;
              emit     = 1'b1;
              left_nxt = left_dec;
              if (left_dec == 8'd0) begin
                phase_nxt = PH_WIDTH;
                done      = 1'b1;
              end
            end
          endcase
          // last in run unless another whole sample still fits in this byte's remaining bits
          smp_last = done || (room < need3);
        end else begin
          part_nxt = part_new;
          pb_nxt   = pb_r + DW_W'(take);
        end
      end
      default: begin
      end
    endcase
  end

  assign off_nxt  = done ? 3'd0 : off_new[2:0];
  assign out_free = !ov_r || out_if.ready;
  assign go       = q_if.valid && (out_free || !emit);
  assign q_if.ready = go && done;

  assign stat.phase    = phase_r;
  assign stat.emit     = go && emit;
  assign stat.pop_last = go && done && item.frame_last;

  always_comb begin
    ov_nxt = ov_r;
    if (go && emit) begin
      ov_nxt = 1'b1;
    end else if (out_if.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      kind_r  <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      sz_r    <= '0;
      gath_r  <= '0;
      gcnt_r  <= '0;
      dw_r    <= '0;
      left_r  <= '0;
      axis_r  <= '0;
      part_r  <= '0;
      pb_r    <= '0;
      off_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (go) begin
        sx_r <= sx_nxt;
        sy_r <= sy_nxt;
        sz_r <= sz_nxt;
        if (done && item.frame_last) begin
          // frame end: per-frame state back to reset, sums kept
          phase_r <= PH_HEADER;
          kind_r  <= '0;
          gath_r  <= '0;
          gcnt_r  <= '0;
          dw_r    <= '0;
          left_r  <= '0;
          axis_r  <= '0;
          part_r  <= '0;
          pb_r    <= '0;
          off_r   <= '0;
        end else begin
          phase_r <= phase_nxt;
          kind_r  <= kind_nxt;
          gath_r  <= gath_nxt;
          gcnt_r  <= gcnt_nxt;
          dw_r    <= dw_nxt;
          left_r  <= left_nxt;
          axis_r  <= axis_nxt;
          part_r  <= part_nxt;
          pb_r    <= pb_nxt;
          off_r   <= off_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      ox_r    <= sx_nxt;
      oy_r    <= sy_nxt;
      oz_r    <= sz_nxt;
      olast_r <= smp_last;
    end
  end

  assign out_if.valid       = ov_r;
  assign out_if.accel_x     = ox_r;
  assign out_if.accel_y     = oy_r;
  assign out_if.accel_z     = oz_r;
  assign out_if.last_in_run = olast_r;

endmodule

FILE: tb/sv/adf_sample_checker.sv
// Checker for the delta frame decoder: predicts samples from input beats and compares results.
module adf_sample_checker
  import adf_pkg::*;
#(
  parameter int MAX_DELTA_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  adf_in_if    in_ch,
  adf_out_if   out_ch,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        run_end;
  } sample_t;

  sample_t samples_due[$];
  sample_t byte_samples[$];
  sample_t seen;
  sample_t wanted;

  // decoder state as predicted
  logic [4:0]  byte_idx;
  logic [7:0]  kind;
  logic [2:0]  phase;
  logic [15:0] acc_x;
  logic [15:0] acc_y;
  logic [15:0] acc_z;
  logic [39:0] triple_buf;
  int          triple_fill;
  logic [5:0]  dwidth;
  logic [7:0]  samples_todo;
  int          axis_sel;
  logic [31:0] delta_bits;
  int          delta_fill;

  // per-frame state only; the sums carry over
  function automatic void restart_frame();
    byte_idx     = '0;
    kind         = '0;
    phase        = PH_HEADER;
    triple_buf   = '0;
    triple_fill  = 0;
    dwidth       = '0;
    samples_todo = '0;
    axis_sel     = 0;
    delta_bits   = '0;
    delta_fill   = 0;
  endfunction

  function automatic void capture();
    if (byte_samples.size() < 3) byte_samples.push_back('{acc_x, acc_y, acc_z, 1'b0});
  endfunction

  // six bytes make a triple; 1 once the sums are loaded
  function automatic bit take_triple_byte(input logic [7:0] b);
    if (triple_fill < 5) begin
      triple_buf[8*triple_fill +: 8] = b;
      triple_fill++;
      return 1'b0;
    end
    acc_x       = triple_buf[15:0];
    acc_y       = triple_buf[31:16];
    acc_z       = {b, triple_buf[39:32]};
    triple_buf  = '0;
    triple_fill = 0;
    return 1'b1;
  endfunction

  function automatic void report(string why, sample_t want, sample_t got);
    if (mismatches < 10)
      $display("%0t ns %s: exp x=%0d y=%0d z=%0d last=%0b  got x=%0d y=%0d z=%0d last=%0b",
               $time, why, $signed(want.x), $signed(want.y), $signed(want.z), want.run_end,
               $signed(got.x), $signed(got.y), $signed(got.z), got.run_end);
    mismatches++;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [31:0] ext;
    logic [15:0] d;
    bit          group_done;
    sample_t     s;
    byte_samples.delete();
    group_done = 1'b0;
    case (phase)
      PH_HEADER: begin
        if (byte_idx == 5'd0) begin
          if (b != MEAS_TYPE) phase = PH_STOPPED;
        end else if (byte_idx == POS_KIND) begin
          kind = b;
        end else if (byte_idx >= POS_BODY) begin
          if (take_triple_byte(b)) begin
            capture();
            phase = (kind == KIND_RAW) ? PH_RAW : PH_WIDTH;
          end
        end
      end
      PH_RAW: begin
        if (take_triple_byte(b)) capture();
      end
      PH_WIDTH: begin
        if (b == 8'd0 || b > MAX_DELTA_BITS) begin
          phase = PH_STOPPED;
        end else begin
          dwidth = b[5:0];
          phase  = PH_COUNT;
        end
      end
      PH_COUNT: begin
        samples_todo = b;
        axis_sel     = 0;
        delta_bits   = '0;
        delta_fill   = 0;
        phase        = (b == 8'd0) ? PH_WIDTH : PH_DELTAS;
      end
      PH_DELTAS: begin
        // LSB first; bits after the group's last delta are padding
        for (int i = 0; i < 8 && !group_done; i++) begin
          if (delta_fill < 32) delta_bits[delta_fill] = b[i];
          delta_fill++;
          if (delta_fill >= dwidth) begin
            ext = delta_bits;
            if (dwidth < 6'd32 && ext[dwidth - 1]) ext = ext | (32'hFFFF_FFFF << dwidth);
            d = ext[15:0];
            case (axis_sel)
              0:       acc_x = acc_x + d;
              1:       acc_y = acc_y + d;
              default: acc_z = acc_z + d;
            endcase
            delta_bits = '0;
            delta_fill = 0;
            axis_sel++;
            if (axis_sel == 3) begin
              axis_sel = 0;
              capture();
              samples_todo--;
              if (samples_todo == 8'd0) begin
                phase      = PH_WIDTH;
                group_done = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (byte_idx < POS_SAT) byte_idx++;
    foreach (byte_samples[k]) begin
      s         = byte_samples[k];
      s.run_end = (k == byte_samples.size() - 1);
      samples_due.push_back(s);
    end
    if (fin) restart_frame();
  endtask

  // results first: a sample can never stem from the beat taken at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_frame();
      acc_x       = '0;
      acc_y       = '0;
      acc_z       = '0;
      samples_due.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen = '{out_ch.accel_x, out_ch.accel_y, out_ch.accel_z, out_ch.last_in_run};
        if (samples_due.size() == 0) begin
          report("sample with none due", '0, seen);
        end else begin
          wanted = samples_due.pop_front();
          if (seen.x !== wanted.x || seen.y !== wanted.y || seen.z !== wanted.z ||
              seen.run_end !== wanted.run_end)
            report("sample mismatch", wanted, seen);
        end
      end
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data_byte, in_ch.frame_last);
      outstanding = samples_due.size();
    end
  end

endmodule

FILE: tb/sv/tb_accel_delta_frame_decoder_unit.sv
// Testbench top for the delta frame decoder: frame stimulus, receiver back-pressure, verdict.
module tb_accel_delta_frame_decoder_unit
  import adf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DELTA_BITS  = 32;
  localparam int RANDOM_BYTES    = 320;
  localparam int HOLD_OFF_CYCLES = 400;
  // worst beat: longest input gap, back-end extraction, three samples each held by the receiver
  localparam int CYCLE_LIMIT     = 600_000;
  localparam int DRAIN_CYCLES    = 64;

  localparam logic [7:0] KIND_DELTA = 8'h00;  // any kind other than raw
  localparam logic [7:0] WIDTH_STOP = 8'h00;  // zero width ends decoding

  logic       clk;
  logic       rst_n;
  int         mismatches;
  int         outstanding;
  int         cycle_count;
  int         random_bytes;
  bit         no_gaps;   // whole frame sent back to back
  bit         squeeze;   // asks the receiver for its one long hold-off
  logic [7:0] frame_q[$];

  adf_in_if  in_ch();
  adf_out_if out_ch();

  accel_delta_frame_decoder_unit #(
    .MAX_DELTA_BITS(MAX_DELTA_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  adf_sample_checker #(
    .MAX_DELTA_BITS(MAX_DELTA_BITS)
  ) sample_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // One beat on the input channel. Called at a falling edge, returns at the falling edge
  // after acceptance; valid stays high between back-to-back beats.
  task automatic push_byte(input logic [7:0] b, input logic fin);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) gap = 0;
    else if (r < 88)       gap = $urandom_range(1, 3);
    else if (r < 97)       gap = $urandom_range(4, 10);
    else                   gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.frame_last <= fin;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // frame_last goes on the final byte
  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) push_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  function automatic void add_noise(input int n);
    repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // type byte, eight don't-care bytes, kind, reference triple
  function automatic void open_frame(input logic [7:0] kind);
    frame_q.push_back(MEAS_TYPE);
    add_noise(8);
    frame_q.push_back(kind);
    add_noise(TRIPLE_BYTES);
  endfunction

  // Receiver: random ready pattern, mostly short stalls, some long ones, some long
  // stretches with no stall. Once asked, it holds off for a long run so the
  // output register and the queue fill and the input side backs up.
  initial begin
    int r;
    bit held;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (squeeze && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_ch.ready <= 1'b1;
          repeat ($urandom_range(1, 16)) @(negedge clk);
        end else if (r < 60) begin
          out_ch.ready <= 1'b1;
          repeat ($urandom_range(40, 120)) @(negedge clk);
        end else if (r < 90) begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(negedge clk);
        end else if (r < 97) begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(4, 12)) @(negedge clk);
        end else begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(25, 60)) @(negedge clk);
        end
      end
    end
  end

  initial begin
    int         r;
    int         w;
    int         c;
    int         nbytes;
    int         groups;
    bit         cut;
    logic [7:0] b;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.frame_last = 1'b0;
    no_gaps          = 1'b0;
    squeeze          = 1'b0;
    random_bytes     = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed. Bad measurement type: the rest of the frame must be ignored.
    frame_q = '{8'hFD, 8'hFF};
    send_frame();

    // Delta frame: reference triple at the extremes (x max, y min, z -1), then
    // width 1 with three samples, which spans two beats and leaves padding and
    // wraps y; a group with zero count; zero width ends the frame.
    frame_q = '{MEAS_TYPE, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hAA, 8'h55,
                KIND_DELTA, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF,
                8'd1, 8'd3, 8'hFF, 8'h01,
                8'd5, 8'd0,
                WIDTH_STOP};
    send_frame();

    // Random frames: mostly well-formed raw and delta frames with random content,
    // the rest short frames, bad types and broken endings.
    while (random_bytes < RANDOM_BYTES) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // bad type; ignored bytes do not count
        do b = 8'($urandom_range(0, 255)); while (b == MEAS_TYPE);
        frame_q.push_back(b);
        add_noise($urandom_range(0, 20));
      end else if (r < 16) begin
        // short frame, ends before the first triple is complete
        frame_q.push_back(MEAS_TYPE);
        add_noise($urandom_range(0, 14));
        random_bytes += frame_q.size();
      end else if (r < 38) begin
        // raw triples, now and then a cut-off one at the end
        open_frame(KIND_RAW);
        add_noise(TRIPLE_BYTES * $urandom_range(0, 4));
        if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 5));
        random_bytes += frame_q.size();
      end else begin
        do b = 8'($urandom_range(0, 255)); while (b == KIND_RAW);
        open_frame(b);
        groups = $urandom_range(1, 4);
        cut    = 1'b0;
        for (int g = 0; g < groups && !cut; g++) begin
          r = $urandom_range(0, 99);
          if (r < 15)      w = MAX_DELTA_BITS;
          else if (r < 30) w = 1;
          else if (r < 45) w = $urandom_range(2, 4);
          else             w = $urandom_range(1, MAX_DELTA_BITS);
          r = $urandom_range(0, 99);
          if (r < 15)      c = 0;
          else if (r < 85) c = $urandom_range(1, 4);
          else             c = $urandom_range(5, 255);
          frame_q.push_back(8'(w));
          frame_q.push_back(8'(c));
          nbytes = (3 * c * w + 7) / 8;
          // long groups are cut short by the frame end
          if (nbytes > 24) begin
            add_noise($urandom_range(1, 12));
            cut = 1'b1;
          end else begin
            add_noise(nbytes);
          end
        end
        if (!cut) begin
          r = $urandom_range(0, 99);
          if (r < 40) begin
            frame_q.push_back(WIDTH_STOP);
            add_noise($urandom_range(0, 3));
          end else if (r < 60) begin
            frame_q.push_back(8'($urandom_range(255, MAX_DELTA_BITS + 1)));
            add_noise($urandom_range(0, 3));
          end else if (r < 80 && frame_q.size() > 17) begin
            // drop the final byte: the last group or sample is left open
            void'(frame_q.pop_back());
          end
        end
        random_bytes += frame_q.size();
      end
      send_frame();
      squeeze = 1'b1;
    end

    in_ch.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: accel_delta_frame_decoder_unit.f
+incdir+rtl
rtl/adf_pkg.sv
rtl/adf_in_if.sv
rtl/adf_out_if.sv
rtl/adf_q_if.sv
rtl/adf_front.sv
rtl/adf_queue.sv
rtl/adf_back.sv
rtl/accel_delta_frame_decoder_unit.sv
tb/sv/adf_sample_checker.sv
tb/sv/tb_accel_delta_frame_decoder_unit.sv
